@@ src/pop_pkg.sv @@
// Shared widths, codes, beat types and rounding helper for the polyline oversampler.
package pop_pkg;

  localparam int COORD_BITS    = 24;
  localparam int FRAC_BITS     = 16;
  localparam int MAX_INSERTED  = 63;
  localparam int CNT_BITS      = 6;
  localparam int FUNC_BITS     = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int STEP_BITS     = (FRAC_BITS < CFG_DATA_BITS) ? FRAC_BITS : CFG_DATA_BITS;
  localparam int FACT_BITS     = FRAC_BITS + CNT_BITS;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS     = DIFF_BITS + FACT_BITS + 1;
  localparam int SUM_BITS      = PROD_BITS + 1;

  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(16384);
  localparam logic [CNT_BITS-1:0]  CNT_RESET  = CNT_BITS'(3);
  localparam logic [CNT_BITS-1:0]  CNT_MAX    = CNT_BITS'(MAX_INSERTED);

  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_FRACTION  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_INSERTED_COUNT = CFG_IDX_BITS'(1);

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_START = 2'd0,
    FUNC_POINT = 2'd1,
    FUNC_END   = 2'd2
  } func_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic [FACT_BITS-1:0]         fact_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;

  // one interpolation job handed from the sequencer to the datapath
  typedef struct packed {
    coord_t base_x;
    coord_t base_y;
    coord_t base_z;
    diff_t  diff_x;
    diff_t  diff_y;
    diff_t  diff_z;
    fact_t  fact;
    logic   last;
    logic   pend;
  } gen_beat_t;

  typedef struct packed {
    coord_t base_x;
    coord_t base_y;
    coord_t base_z;
    prod_t  prod_x;
    prod_t  prod_y;
    prod_t  prod_z;
    logic   last;
    logic   pend;
  } mul_beat_t;

  typedef struct packed {
    coord_t val;
    logic   sat;
  } lerp_res_t;

  // round product to nearest (ties up), add base, clamp to coordinate range
  function automatic lerp_res_t lerp_round_sat(input coord_t base, input prod_t prod);
    prod_t     rnd;
    sum_t      r;
    sum_t      hi;
    sum_t      lo;
    lerp_res_t res;
    rnd = prod + (prod_t'(1) <<< (FRAC_BITS - 1));
    r   = sum_t'(base) + sum_t'(rnd >>> FRAC_BITS);
    hi  = (sum_t'(1) <<< (COORD_BITS - 1)) - sum_t'(1);
    lo  = -hi - sum_t'(1);
    if (r > hi) begin
      res.val = hi[COORD_BITS-1:0];
      res.sat = 1'b1;
    end else if (r < lo) begin
      res.val = lo[COORD_BITS-1:0];
      res.sat = 1'b1;
    end else begin
      res.val = r[COORD_BITS-1:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

endpackage

@@ src/pop_if.sv @@
// Handshake channels of the polyline oversampler: points in, results out, configuration.
interface pop_in_if import pop_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_BITS-1:0] func;
  coord_t               in_x;
  coord_t               in_y;
  coord_t               in_z;
  modport source(output valid, func, in_x, in_y, in_z, input ready);
  modport sink(input valid, func, in_x, in_y, in_z, output ready);
endinterface

interface pop_out_if import pop_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   run_last;
  logic   polyline_end;
  logic   saturated;
  modport source(output valid, out_x, out_y, out_z, run_last, polyline_end, saturated,
                 input ready);
  modport sink(input valid, out_x, out_y, out_z, run_last, polyline_end, saturated,
               output ready);
endinterface

interface pop_cfg_if import pop_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ src/pop_seq.sv @@
// Point sequencer: config registers, stored point and per-result interpolation job generator.
module pop_seq import pop_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pop_in_if.sink     pts,
  pop_cfg_if.sink    cfg,
  output gen_beat_t  beat,
  output logic       beat_valid,
  input  logic       beat_ready
);

  logic [STEP_BITS-1:0] step_fraction;
  logic [CNT_BITS-1:0]  inserted_count;
  logic [CNT_BITS-1:0]  cnt_eff;

  coord_t prev_x, prev_y, prev_z;
  logic   have_prev;

  logic                gv;
  coord_t              g_base_x, g_base_y, g_base_z;
  diff_t               g_diff_x, g_diff_y, g_diff_z;
  logic [CNT_BITS-1:0] g_cnt;
  logic [CNT_BITS-1:0] g_k;
  fact_t               g_fact;
  logic                g_pend;

  logic gen_last;
  logic beat_fire;
  logic accept;
  logic is_point;
  logic is_end;
  logic load;

  assign cfg.ready = 1'b1;
  assign cnt_eff   = (inserted_count > CNT_MAX) ? CNT_MAX : inserted_count;

  assign gen_last  = (g_k == g_cnt);
  assign beat_fire = gv && beat_ready;
  assign pts.ready = !gv || (beat_ready && gen_last);
  assign accept    = pts.valid && pts.ready;
  assign is_point  = (pts.func == FUNC_POINT);
  assign is_end    = (pts.func == FUNC_END);
  assign load      = accept && have_prev && (is_point || is_end);

  assign beat_valid    = gv;
  assign beat.base_x   = g_base_x;
  assign beat.base_y   = g_base_y;
  assign beat.base_z   = g_base_z;
  assign beat.diff_x   = g_diff_x;
  assign beat.diff_y   = g_diff_y;
  assign beat.diff_z   = g_diff_z;
  assign beat.fact     = g_fact;
  assign beat.last     = gen_last;
  assign beat.pend     = g_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_fraction  <= STEP_RESET;
      inserted_count <= CNT_RESET;
      have_prev      <= 1'b0;
      prev_x         <= '0;
      prev_y         <= '0;
      prev_z         <= '0;
      gv             <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_STEP_FRACTION: begin
            step_fraction <= cfg.data[STEP_BITS-1:0];
          end
          REG_INSERTED_COUNT: begin
            inserted_count <= cfg.data[CNT_BITS-1:0];
          end
          default: ;
        endcase
      end

      if (accept) begin
        unique case (pts.func)
          FUNC_START: have_prev <= 1'b0;
          FUNC_POINT: begin
            prev_x    <= pts.in_x;
            prev_y    <= pts.in_y;
            prev_z    <= pts.in_z;
            have_prev <= 1'b1;
          end
          FUNC_END:   have_prev <= 1'b0;
          default:    ;
        endcase
      end

      if (load) begin
        gv <= 1'b1;
      end else if (beat_fire && gen_last) begin
        gv <= 1'b0;
      end

      // end event replays the stored point once; a point walks k = 0..count
      if (load) begin
        g_base_x <= prev_x;
        g_base_y <= prev_y;
        g_base_z <= prev_z;
        g_diff_x <= is_point ? diff_t'(pts.in_x) - diff_t'(prev_x) : '0;
        g_diff_y <= is_point ? diff_t'(pts.in_y) - diff_t'(prev_y) : '0;
        g_diff_z <= is_point ? diff_t'(pts.in_z) - diff_t'(prev_z) : '0;
        g_cnt    <= is_point ? cnt_eff : '0;
        g_k      <= '0;
        g_fact   <= '0;
        g_pend   <= is_end;
      end else if (beat_fire && !gen_last) begin
        g_k    <= g_k + CNT_BITS'(1);
        g_fact <= g_fact + fact_t'(step_fraction);
      end
    end
  end

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    !pts.ready |-> gv)
    else $error("input stalled with no job in progress");

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    gv |-> (g_k <= g_cnt))
    else $error("result index ran past inserted count");

  a_end_single: assert property (@(posedge clk) disable iff (rst)
    (gv && g_pend) |-> (g_cnt == '0 && g_diff_x == '0 && g_diff_y == '0 && g_diff_z == '0))
    else $error("end-of-polyline job must replay the stored point only");

  a_job_retires: assert property (@(posedge clk) disable iff (rst)
    (beat_fire && gen_last && !load) |=> !gv)
    else $error("job did not retire after its last beat");

endmodule

@@ src/pop_lerp.sv @@
// Interpolation datapath: multiply stage, then round, add, saturate into the result register.
module pop_lerp import pop_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  gen_beat_t  beat,
  input  logic       beat_valid,
  output logic       beat_ready,
  pop_out_if.source  res
);

  logic      bv;
  mul_beat_t mb;
  logic      out_free;
  lerp_res_t rx, ry, rz;

  assign out_free   = !res.valid || res.ready;
  assign beat_ready = !bv || out_free;

  assign rx = lerp_round_sat(mb.base_x, mb.prod_x);
  assign ry = lerp_round_sat(mb.base_y, mb.prod_y);
  assign rz = lerp_round_sat(mb.base_z, mb.prod_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      bv        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (beat_ready) begin
        bv <= beat_valid;
      end
      if (beat_valid && beat_ready) begin
        mb.base_x <= beat.base_x;
        mb.base_y <= beat.base_y;
        mb.base_z <= beat.base_z;
        mb.prod_x <= prod_t'(beat.diff_x) * prod_t'(beat.fact);
        mb.prod_y <= prod_t'(beat.diff_y) * prod_t'(beat.fact);
        mb.prod_z <= prod_t'(beat.diff_z) * prod_t'(beat.fact);
        mb.last   <= beat.last;
        mb.pend   <= beat.pend;
      end

      if (out_free) begin
        res.valid <= bv;
      end
      if (bv && out_free) begin
        res.out_x        <= rx.val;
        res.out_y        <= ry.val;
        res.out_z        <= rz.val;
        res.run_last     <= mb.last;
        res.polyline_end <= mb.pend;
        res.saturated    <= rx.sat | ry.sat | rz.sat;
      end
    end
  end

endmodule

@@ src/polyline_point_oversampler.sv @@
// Each result passes the job generator, multiply stage and result register in turn.
// A point following a stored point yields inserted_count + 1 results, one result
// per cycle from the job generator while the output does not stall.
// The generator, multiply stage and result register overlap successive items.
// Reset (synchronous, active high) drops the stored point, empties the pipeline
// and sets step_fraction to 16384 and inserted_count to 3.
module polyline_point_oversampler import pop_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pop_in_if.sink    points_in,
  pop_cfg_if.sink   cfg,
  pop_out_if.source points_out
);

  gen_beat_t beat;
  logic      beat_valid;
  logic      beat_ready;

  pop_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .pts        (points_in),
    .cfg        (cfg),
    .beat       (beat),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready)
  );

  pop_lerp u_lerp (
    .clk        (clk),
    .rst        (rst),
    .beat       (beat),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .res        (points_out)
  );

endmodule
